// File: design/kl_divergence_accumulator_macros.svh
// Assertion macros used by the divergence accumulator back end.
`ifndef KL_DIVERGENCE_ACCUMULATOR_MACROS_SVH
`define KL_DIVERGENCE_ACCUMULATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KLA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/kla_pkg.sv
// Shared defaults and types of the divergence accumulator.
package kla_pkg;

    // Default sizes of the block.
    localparam int PROB_BITS_DEF      = 16;
    localparam int LOG_TABLE_BITS_DEF = 10;
    localparam int ACC_BITS_DEF       = 48;

    // Control of the job at the head of the queue between front and back.
    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
    } t_job_ctrl;

endpackage

// File: design/kla_front.sv
// Front end: accepts probability pairs, classifies them and queues the jobs.
module kla_front #(
    parameter int PROB_BITS      = kla_pkg::PROB_BITS_DEF,
    parameter int LOG_TABLE_BITS = kla_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [PROB_BITS-1:0]         i_true_prob,
    input  logic [PROB_BITS-1:0]         i_pred_prob,
    input  logic                         i_last,
    output kla_pkg::t_job_ctrl           o_job,
    output logic [PROB_BITS-1:0]         o_job_p,
    output logic [$clog2(PROB_BITS)-1:0] o_job_ep,
    output logic [LOG_TABLE_BITS-1:0]    o_job_idxp,
    output logic [15:0]                  o_job_rp,
    output logic [$clog2(PROB_BITS)-1:0] o_job_eq,
    output logic [LOG_TABLE_BITS-1:0]    o_job_idxq,
    output logic [15:0]                  o_job_rq,
    input  logic                         i_pop
);

    localparam int E_BITS = $clog2(PROB_BITS);
    localparam int EXT_W  = PROB_BITS - 1 + LOG_TABLE_BITS + 16;
    localparam int DEPTH  = 2;

    // Index of the leading one; zero for a zero word.
    function automatic logic [E_BITS-1:0] lead_one(input logic [PROB_BITS-1:0] x);
        logic [E_BITS-1:0] e;
        e = '0;
        for (int i = 0; i < PROB_BITS; i++) begin
            if (x[i]) begin
                e = E_BITS'(i);
            end
        end
        return e;
    endfunction

    logic                      w_accept;
    logic [E_BITS-1:0]         w_ep;
    logic [E_BITS-1:0]         w_eq;
    logic [PROB_BITS-1:0]      w_norm_p;
    logic [PROB_BITS-1:0]      w_norm_q;
    logic [EXT_W-1:0]          w_ext_p;
    logic [EXT_W-1:0]          w_ext_q;
    logic                      w_zero;

    logic [1:0]                r_count;
    logic                      r_wptr;
    logic                      r_rptr;

    logic [PROB_BITS-1:0]      r_q_p    [DEPTH];
    logic [E_BITS-1:0]         r_q_ep   [DEPTH];
    logic [LOG_TABLE_BITS-1:0] r_q_idxp [DEPTH];
    logic [15:0]               r_q_rp   [DEPTH];
    logic [E_BITS-1:0]         r_q_eq   [DEPTH];
    logic [LOG_TABLE_BITS-1:0] r_q_idxq [DEPTH];
    logic [15:0]               r_q_rq   [DEPTH];
    logic                      r_q_last [DEPTH];
    logic                      r_q_zero [DEPTH];

    assign o_in_stall = (r_count == 2'(DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;

    // Normalize each probability so that its leading one sits at the top bit,
    // then split the bits below it into table index and interpolation weight.
    assign w_ep     = lead_one(i_true_prob);
    assign w_eq     = lead_one(i_pred_prob);
    assign w_norm_p = i_true_prob << (E_BITS'(PROB_BITS - 1) - w_ep);
    assign w_norm_q = i_pred_prob << (E_BITS'(PROB_BITS - 1) - w_eq);
    assign w_ext_p  = {w_norm_p[PROB_BITS-2:0], {(LOG_TABLE_BITS + 16){1'b0}}};
    assign w_ext_q  = {w_norm_q[PROB_BITS-2:0], {(LOG_TABLE_BITS + 16){1'b0}}};
    assign w_zero   = (i_true_prob == '0) || (i_pred_prob == '0);

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (w_accept && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_accept && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_p[r_wptr]    <= i_true_prob;
            r_q_ep[r_wptr]   <= w_ep;
            r_q_idxp[r_wptr] <= w_ext_p[EXT_W-1 -: LOG_TABLE_BITS];
            r_q_rp[r_wptr]   <= w_ext_p[EXT_W-1-LOG_TABLE_BITS -: 16];
            r_q_eq[r_wptr]   <= w_eq;
            r_q_idxq[r_wptr] <= w_ext_q[EXT_W-1 -: LOG_TABLE_BITS];
            r_q_rq[r_wptr]   <= w_ext_q[EXT_W-1-LOG_TABLE_BITS -: 16];
            r_q_last[r_wptr] <= i_last;
            r_q_zero[r_wptr] <= w_zero;
        end
    end

    // Head of the queue.
    assign o_job.valid = (r_count != 2'd0);
    assign o_job.last  = r_q_last[r_rptr];
    assign o_job.zero  = r_q_zero[r_rptr];
    assign o_job_p     = r_q_p[r_rptr];
    assign o_job_ep    = r_q_ep[r_rptr];
    assign o_job_idxp  = r_q_idxp[r_rptr];
    assign o_job_rp    = r_q_rp[r_rptr];
    assign o_job_eq    = r_q_eq[r_rptr];
    assign o_job_idxq  = r_q_idxq[r_rptr];
    assign o_job_rq    = r_q_rq[r_rptr];

endmodule

// File: design/kla_back.sv
// Back end: log table lookups, divergence term and saturating accumulation.
`include "kl_divergence_accumulator_macros.svh"

module kla_back #(
    parameter int PROB_BITS      = kla_pkg::PROB_BITS_DEF,
    parameter int LOG_TABLE_BITS = kla_pkg::LOG_TABLE_BITS_DEF,
    parameter int ACC_BITS       = kla_pkg::ACC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kla_pkg::t_job_ctrl           i_job,
    input  logic [PROB_BITS-1:0]         i_job_p,
    input  logic [$clog2(PROB_BITS)-1:0] i_job_ep,
    input  logic [LOG_TABLE_BITS-1:0]    i_job_idxp,
    input  logic [15:0]                  i_job_rp,
    input  logic [$clog2(PROB_BITS)-1:0] i_job_eq,
    input  logic [LOG_TABLE_BITS-1:0]    i_job_idxq,
    input  logic [15:0]                  i_job_rq,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [ACC_BITS-1:0]   o_kl_sum,
    output logic                         o_bad_input
);

    localparam int E_BITS    = $clog2(PROB_BITS);
    localparam int L_BITS    = E_BITS + 30;
    localparam int MAG_LO    = L_BITS / 2;
    localparam int MAG_HI    = L_BITS - MAG_LO;
    localparam int PROD_BITS = L_BITS + 28;
    localparam int LN_BITS   = E_BITS + 16;
    localparam int PT_W      = PROB_BITS + LN_BITS + 1;
    localparam int TAB       = (1 << LOG_TABLE_BITS) + 1;
    localparam int AW        = LOG_TABLE_BITS + 1;

    localparam logic [27:0]          LN2_Q28 = 28'd186065279;
    localparam logic [PROD_BITS:0]   RND27   = (PROD_BITS + 1)'(1) << 27;
    localparam logic [PROD_BITS:0]   RND13   = (PROD_BITS + 1)'(1) << 13;
    localparam logic [PT_W-1:0]      RNDP    = PT_W'(1) << (PROB_BITS - 1);
    localparam logic [ACC_BITS-1:0]  ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
    localparam logic [ACC_BITS-1:0]  ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_LKP  = 10'b00_0000_0010,
        S_INTP = 10'b00_0000_0100,
        S_INTQ = 10'b00_0000_1000,
        S_MAG  = 10'b00_0001_0000,
        S_ML   = 10'b00_0010_0000,
        S_MH   = 10'b00_0100_0000,
        S_RND  = 10'b00_1000_0000,
        S_TERM = 10'b01_0000_0000,
        S_ACC  = 10'b10_0000_0000
    } t_state;

    // log2(1 + k / 2^LOG_TABLE_BITS) in Q.30 by repeated squaring, truncated.
    function automatic logic [30:0] log_entry(input int k);
        logic [63:0] m;
        logic [30:0] y;
        y = '0;
        m = (64'd1 << 30) + (64'(k) << (30 - LOG_TABLE_BITS));
        if (k == (1 << LOG_TABLE_BITS)) begin
            y = 31'd1 << 30;
        end else begin
            for (int i = 1; i <= 30; i++) begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    y[30-i] = 1'b1;
                end
            end
        end
        return y;
    endfunction

    t_state                    r_state;
    t_state                    n_state;

    logic [30:0]               w_rom [TAB];
    logic [LOG_TABLE_BITS-1:0] w_addr;
    logic [30:0]               r_lo;
    logic [30:0]               r_hi;

    logic [PROB_BITS-1:0]      r_p;
    logic [E_BITS-1:0]         r_ep;
    logic [LOG_TABLE_BITS-1:0] r_idxp;
    logic [15:0]               r_rp;
    logic [E_BITS-1:0]         r_eq;
    logic [LOG_TABLE_BITS-1:0] r_idxq;
    logic [15:0]               r_rq;
    logic                      r_last;
    logic                      r_zero;

    logic [30:0]               w_delta;
    logic [15:0]               w_wt;
    logic [E_BITS-1:0]         w_e;
    logic [46:0]               w_ip;
    logic [30:0]               w_frac;
    logic [L_BITS-1:0]         w_l;
    logic [L_BITS-1:0]         r_lp;
    logic [L_BITS-1:0]         r_lq;
    logic [L_BITS-1:0]         r_mag;
    logic                      r_neg;

    logic [MAG_LO+27:0]        w_plo;
    logic [MAG_HI+27:0]        w_phi;
    logic [PROD_BITS-1:0]      r_prod;
    logic [PROD_BITS:0]        w_r30;
    logic [PROD_BITS:0]        w_ln30;
    logic [PROD_BITS:0]        w_r16;
    logic [LN_BITS-1:0]        r_ln16;
    logic [PT_W-1:0]           w_pt;
    logic [LN_BITS-1:0]        r_term;

    logic [ACC_BITS:0]         w_ext;
    logic [ACC_BITS:0]         w_t;
    logic [ACC_BITS:0]         w_s;
    logic [ACC_BITS-1:0]       w_sum;
    logic                      w_out_free;
    logic                      w_done;
    logic signed [ACC_BITS-1:0] r_sum;
    logic                      r_err;

    logic                      r_out_valid;
    logic [ACC_BITS-1:0]       r_out_sum;
    logic                      r_out_bad;

    logic                      w_acc;
    logic                      w_zero_pop;
    logic                      w_last_done;
    logic                      w_result_set;
    logic                      w_slot_wait;
    logic                      w_held;

    // Constant log table, one entry past the end for interpolation.
    for (genvar k = 0; k < TAB; k++) begin : g_rom
        assign w_rom[k] = log_entry(k);
    end

    // Two registered table reads: the entry and its upper neighbor.
    assign w_addr = r_state[1] ? r_idxp : r_idxq;

    always_ff @(posedge i_clk) begin
        r_lo <= w_rom[{1'b0, w_addr}];
        r_hi <= w_rom[{1'b0, w_addr} + AW'(1)];
    end

    // Linear interpolation between table entries; the result stays below 2^30.
    assign w_wt    = (r_state == S_INTP) ? r_rp : r_rq;
    assign w_e     = (r_state == S_INTP) ? r_ep : r_eq;
    assign w_delta = r_hi - r_lo;
    assign w_ip    = w_delta * w_wt;
    assign w_frac  = r_lo + w_ip[46:16];
    assign w_l     = {w_e, w_frac[29:0]};

    // Scaling by ln2 is split into two partial products.
    assign w_plo = r_mag[MAG_LO-1:0] * LN2_Q28;
    assign w_phi = r_mag[L_BITS-1:MAG_LO] * LN2_Q28;

    // Round to Q.30, then to Q.16, both half up on the magnitude.
    assign w_r30  = {1'b0, r_prod} + RND27;
    assign w_ln30 = w_r30 >> 28;
    assign w_r16  = w_ln30 + RND13;

    // Weight by p and round.
    assign w_pt = PT_W'(r_p) * PT_W'(r_ln16) + RNDP;

    // Saturating add or subtract of the term magnitude.
    assign w_ext = {r_sum[ACC_BITS-1], r_sum};
    assign w_t   = (ACC_BITS + 1)'(r_term);
    assign w_s   = r_neg ? (w_ext - w_t) : (w_ext + w_t);
    assign w_sum = (w_s[ACC_BITS] != w_s[ACC_BITS-1])
                 ? (w_s[ACC_BITS] ? ACC_MIN : ACC_MAX)
                 : w_s[ACC_BITS-1:0];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_done     = (r_state == S_ACC) && (!r_last || w_out_free);
    assign o_pop      = (r_state == S_IDLE) && i_job.valid;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job.valid) begin
                    n_state = i_job.zero ? S_ACC : S_LKP;
                end
            end
            S_LKP:  n_state = S_INTP;
            S_INTP: n_state = S_INTQ;
            S_INTQ: n_state = S_MAG;
            S_MAG:  n_state = S_ML;
            S_ML:   n_state = S_MH;
            S_MH:   n_state = S_RND;
            S_RND:  n_state = S_TERM;
            S_TERM: n_state = S_ACC;
            S_ACC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, accumulator, error flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done && r_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_done) begin
                if (r_last) begin
                    r_sum <= '0;
                    r_err <= 1'b0;
                end else begin
                    r_sum <= w_sum;
                    r_err <= r_err || r_zero;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_p    <= i_job_p;
                r_ep   <= i_job_ep;
                r_idxp <= i_job_idxp;
                r_rp   <= i_job_rp;
                r_eq   <= i_job_eq;
                r_idxq <= i_job_idxq;
                r_rq   <= i_job_rq;
                r_last <= i_job.last;
                r_zero <= i_job.zero;
                r_term <= '0;
                r_neg  <= 1'b0;
            end
            S_INTP: r_lp <= w_l;
            S_INTQ: r_lq <= w_l;
            S_MAG: begin
                r_neg <= (r_lq > r_lp);
                r_mag <= (r_lq > r_lp) ? (r_lq - r_lp) : (r_lp - r_lq);
            end
            S_ML:   r_prod <= PROD_BITS'(w_plo);
            S_MH:   r_prod <= r_prod + (PROD_BITS'(w_phi) << MAG_LO);
            S_RND:  r_ln16 <= w_r16[14 +: LN_BITS];
            S_TERM: r_term <= w_pt[PROB_BITS +: LN_BITS];
            S_ACC: begin
                if (w_done && r_last) begin
                    r_out_sum <= w_sum;
                    r_out_bad <= r_err || r_zero;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_kl_sum    = r_out_sum;
    assign o_bad_input = r_out_bad;

    // Conditions watched by the checks below.
    assign w_acc        = (r_state == S_ACC);
    assign w_zero_pop   = o_pop && i_job.zero;
    assign w_last_done  = w_done && r_last;
    assign w_result_set = (r_sum == '0) && !r_err && r_out_valid;
    assign w_slot_wait  = w_acc && r_last && !w_out_free;
    assign w_held       = w_acc && r_out_valid;

    // Checks on the sequencer and the accumulator.
    `KLA_ASSERT_IMPL(a_pop_needs_job, i_clk, i_rst_n, o_pop, i_job.valid, "pop from empty queue")
    `KLA_ASSERT_NEXT(a_zero_skips_log, i_clk, i_rst_n, w_zero_pop, w_acc, "zero word not skipped")
    `KLA_ASSERT_NEXT(a_clear_on_last, i_clk, i_rst_n, w_last_done, w_result_set, "sum not cleared")
    `KLA_ASSERT_NEXT(a_wait_for_slot, i_clk, i_rst_n, w_slot_wait, w_held, "slot overwritten")

endmodule

// File: design/kl_divergence_accumulator.sv
// Top level of the Kullback-Leibler divergence accumulator.
// Each word carries a true probability p and a predicted probability q, both unsigned
// Q0.PROB_BITS, and adds p*ln(p/q) to a signed Q(ACC_BITS-17).16 running sum in nats
// that saturates. A zero p or q adds nothing and sets a sticky error flag. On a word
// marked last the sum and the flag go out as one result word and then both clear. The
// front end classifies each word (leading one, table index, interpolation weight) in the
// cycle it is accepted and places it in a two-entry queue, so input is taken while the
// back end works. The back end is a sequencer that handles one word at a time: a word
// with nonzero probabilities passes through two log table lookups in the shared
// two-port table, interpolation, ln2 scaling in two partial products, rounding, the
// weighting by p and the saturating add, while a word with a zero probability goes
// straight to the add. A finished result sits in an output register and stalls the
// back end only when a second result arrives before the first has been taken.
module kl_divergence_accumulator #(
    parameter int PROB_BITS      = kla_pkg::PROB_BITS_DEF,
    parameter int LOG_TABLE_BITS = kla_pkg::LOG_TABLE_BITS_DEF,
    parameter int ACC_BITS       = kla_pkg::ACC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [PROB_BITS-1:0]       i_true_prob,
    input  logic [PROB_BITS-1:0]       i_pred_prob,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [ACC_BITS-1:0] o_kl_sum,
    output logic                       o_bad_input
);

    localparam int E_BITS = $clog2(PROB_BITS);

    kla_pkg::t_job_ctrl        w_job;
    logic [PROB_BITS-1:0]      w_job_p;
    logic [E_BITS-1:0]         w_job_ep;
    logic [LOG_TABLE_BITS-1:0] w_job_idxp;
    logic [15:0]               w_job_rp;
    logic [E_BITS-1:0]         w_job_eq;
    logic [LOG_TABLE_BITS-1:0] w_job_idxq;
    logic [15:0]               w_job_rq;
    logic                      w_pop;

    // Input classification and job queue.
    kla_front #(
        .PROB_BITS      (PROB_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_true_prob (i_true_prob),
        .i_pred_prob (i_pred_prob),
        .i_last      (i_last),
        .o_job       (w_job),
        .o_job_p     (w_job_p),
        .o_job_ep    (w_job_ep),
        .o_job_idxp  (w_job_idxp),
        .o_job_rp    (w_job_rp),
        .o_job_eq    (w_job_eq),
        .o_job_idxq  (w_job_idxq),
        .o_job_rq    (w_job_rq),
        .i_pop       (w_pop)
    );

    // Log, term and accumulation.
    kla_back #(
        .PROB_BITS      (PROB_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS),
        .ACC_BITS       (ACC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_p     (w_job_p),
        .i_job_ep    (w_job_ep),
        .i_job_idxp  (w_job_idxp),
        .i_job_rp    (w_job_rp),
        .i_job_eq    (w_job_eq),
        .i_job_idxq  (w_job_idxq),
        .i_job_rq    (w_job_rq),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kl_sum    (o_kl_sum),
        .o_bad_input (o_bad_input)
    );

endmodule

// File: sim/tb.sv
// Testbench of the divergence accumulator: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int PB  = kla_pkg::PROB_BITS_DEF;
    localparam int LTB = kla_pkg::LOG_TABLE_BITS_DEF;
    localparam int AB  = kla_pkg::ACC_BITS_DEF;
    localparam int WORDS_PER_PHASE = 633;
    localparam logic [63:0] LN2_Q28 = 64'd186065279;

    typedef struct {
        logic [PB-1:0] p;
        logic [PB-1:0] q;
        logic          last;
    } t_prob_word;

    typedef struct {
        logic signed [AB-1:0] kl_sum;
        logic                 bad_input;
    } t_divergence;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [PB-1:0]        i_true_prob = '0;
    logic [PB-1:0]        i_pred_prob = '0;
    logic                 i_last = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [AB-1:0] o_kl_sum;
    logic                 o_bad_input;

    t_prob_word  pending_words[$];
    t_divergence expected_results[$];
    logic [31:0] log2_rom [0:(1 << LTB)];
    longint      running_nats = 0;
    logic        zero_seen = 1'b0;
    int          mismatches = 0;
    int          words_queued = 0;
    int          words_accepted = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    kl_divergence_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_true_prob (i_true_prob),
        .i_pred_prob (i_pred_prob),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kl_sum    (o_kl_sum),
        .o_bad_input (o_bad_input)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Log2 of a Q1.30 mantissa in [1, 2) by repeated squaring, truncated to Q.30.
    function automatic logic [31:0] mantissa_log2(logic [63:0] m);
        logic [31:0] y;
        y = '0;
        for (int i = 1; i <= 30; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                y[30-i] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic void build_log2_rom();
        for (int k = 0; k < (1 << LTB); k++) begin
            log2_rom[k] = mantissa_log2((64'd1 << 30) + (64'(k) << (30 - LTB)));
        end
        log2_rom[1 << LTB] = 32'd1 << 30;
    endfunction

    // Log2 of a nonzero probability in Q.30: leading one, table lookup, interpolation.
    function automatic logic [63:0] prob_log2(logic [PB-1:0] x);
        int          lead;
        logic [63:0] frac;
        logic [63:0] idx;
        logic [63:0] r;
        logic [63:0] lo;
        logic [63:0] hi;
        lead = PB - 1;
        while (lead > 0 && x[lead] == 1'b0) lead--;
        frac = (64'(x) << (63 - lead)) << 1;
        idx = frac >> (64 - LTB);
        r = (frac >> (64 - LTB - 16)) & 64'hFFFF;
        lo = 64'(log2_rom[idx]);
        hi = 64'(log2_rom[idx + 1]);
        return (64'(lead) << 30) + lo + (((hi - lo) * r) >> 16);
    endfunction

    // Adds p*ln(p/q) to the running sum and queues the result on the last word.
    function automatic void accumulate_divergence(logic [PB-1:0] p, logic [PB-1:0] q,
                                                  logic last);
        logic [63:0] lp;
        logic [63:0] lq;
        logic [63:0] mag;
        logic [63:0] ln30;
        logic [63:0] ln16;
        logic [63:0] tmag;
        logic        neg;
        longint      term;
        longint      amax;
        longint      amin;
        t_divergence res;
        amax = (longint'(1) <<< (AB - 1)) - 1;
        amin = -amax - 1;
        if (p == '0 || q == '0) begin
            zero_seen = 1'b1;
        end else begin
            lp = prob_log2(p);
            lq = prob_log2(q);
            neg = lq > lp;
            mag = neg ? lq - lp : lp - lq;
            ln30 = (mag * LN2_Q28 + (64'd1 << 27)) >> 28;
            ln16 = (ln30 + (64'd1 << 13)) >> 14;
            tmag = (64'(p) * ln16 + (64'd1 << (PB - 1))) >> PB;
            term = longint'(tmag);
            if (neg) begin
                if (running_nats < amin + term) running_nats = amin;
                else running_nats = running_nats - term;
            end else begin
                if (running_nats > amax - term) running_nats = amax;
                else running_nats = running_nats + term;
            end
        end
        if (last) begin
            res.kl_sum = running_nats[AB-1:0];
            res.bad_input = zero_seen;
            expected_results.push_back(res);
            running_nats = 0;
            zero_seen = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_word(int p, int q, logic last);
        t_prob_word w;
        w.p = p[PB-1:0];
        w.q = q[PB-1:0];
        w.last = last;
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic int pick_prob();
        int kind;
        kind = $urandom_range(99);
        if (kind < 45) return $urandom_range(1, 65535);
        if (kind < 65) return $urandom_range(1, 255);
        if (kind < 75) return 1 << $urandom_range(0, PB - 1);
        if (kind < 85) return $urandom_range(65000, 65535);
        return $urandom_range(1, 4095);
    endfunction

    // One vector of random length; most words are valid, a few carry a zero probability.
    task automatic queue_random_vector();
        int len;
        int p;
        int q;
        int kind;
        int delta;
        len = ($urandom_range(19) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(99);
            p = pick_prob();
            q = pick_prob();
            if (kind < 25) begin
                delta = $urandom_range(0, 64);
                q = $urandom_range(1) ? p + delta : p - delta;
                if (q < 1) q = 1;
                if (q > 65535) q = 65535;
            end else if (kind < 28) begin
                p = 0;
            end else if (kind < 31) begin
                q = 0;
            end else if (kind < 32) begin
                p = 0;
                q = 0;
            end
            queue_word(p, q, i == len - 1);
        end
    endtask

    // Driver: presents queued words and feeds every accepted word to the predictor.
    always @(posedge i_clk) begin : driver
        t_prob_word w;
        logic       free;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            free = !i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                accumulate_divergence(i_true_prob, i_pred_prob, i_last);
                words_accepted++;
                free = 1'b1;
            end
            if (free) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = pending_words.pop_front();
                    i_true_prob <= w.p;
                    i_pred_prob <= w.q;
                    i_last <= w.last;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word and stalls the output at random.
    always @(posedge i_clk) begin : monitor
        t_divergence want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sum %0d bad %0b",
                                              o_kl_sum, o_bad_input));
                end else begin
                    want = expected_results.pop_front();
                    if (o_kl_sum !== want.kl_sum)
                        report_mismatch($sformatf("kl_sum %0d, want %0d",
                                                  o_kl_sum, want.kl_sum));
                    if (o_bad_input !== want.bad_input)
                        report_mismatch($sformatf("bad_input %0b, want %0b",
                                                  o_bad_input, want.bad_input));
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        build_log2_rom();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            @(negedge i_clk);
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 25 : 0;
            if (phase == 0) begin
                // Equal extremes, largest positive and negative terms.
                queue_word(65535, 65535, 1'b1);
                queue_word(1, 1, 1'b1);
                queue_word(65535, 1, 1'b1);
                queue_word(1, 65535, 1'b1);
                // Zero probabilities set the flag and add nothing.
                queue_word(0, 100, 1'b1);
                queue_word(100, 0, 1'b1);
                queue_word(0, 0, 1'b1);
                // The flag and the sum clear after the last word.
                queue_word(0, 5, 1'b0);
                queue_word(30000, 20000, 1'b1);
                queue_word(30000, 20000, 1'b1);
                // Exact table points, the top table entry and mixed signs.
                queue_word(16'h8000, 16'h4000, 1'b0);
                queue_word(16'h4000, 16'h8000, 1'b0);
                queue_word(16'h8000, 16'h7FFF, 1'b1);
                queue_word(16'h5555, 16'hAAAA, 1'b0);
                queue_word(16'hAAAA, 16'h5555, 1'b1);
                queue_word(16'h0001, 16'h8000, 1'b0);
                queue_word(16'h00FF, 16'hFF00, 1'b0);
                queue_word(16'h7FFF, 16'hFFFF, 1'b1);
            end
            while (words_queued < (phase + 1) * WORDS_PER_PHASE) queue_random_vector();
            wait (words_accepted == words_queued);
            wait (expected_results.size() == 0);
        end

        repeat (40) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
